FILE: sv/ffca_pkg.sv
// Shared constants, types and codes for the first-fit chunk allocator.
package ffca_pkg;

  // Heap size in words, and the part of it that 16-bit start addresses can reach.
  localparam int unsigned HEAP_WORDS     = 65536;
  localparam int unsigned ADDR_SPAN      = 65536;
  localparam int unsigned USABLE_WORDS   = (HEAP_WORDS > ADDR_SPAN) ? ADDR_SPAN : HEAP_WORDS;

  // Default table depth.
  localparam int unsigned MAX_CHUNKS_DEF = 16;

  // Field widths.
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned ENTRY_W = START_W + LEN_W;
  // A chunk end (start plus length) needs one bit more than the length.
  localparam int unsigned END_W   = LEN_W + 1;

  localparam logic [END_W-1:0] USABLE_END = END_W'(USABLE_WORDS);

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } ffca_status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_GROW,
    S_INSERT,
    S_SHRINK,
    S_DONE
  } ffca_state_t;

  // Answers of the shared gap and match unit.
  typedef struct packed {
    logic             fits;
    logic             match;
    logic [END_W-1:0] end_val;
  } gap_res_t;

endpackage

FILE: sv/first_fit_chunk_allocator_top.sv
// Top level of the first-fit chunk allocator: sequencer, chunk table and result register.
//
//   Channel | Ports                                     | Direction
//   --------+-------------------------------------------+----------
//   in      | in_valid in_ready in_kind in_req_size     | request in
//           | in_free_addr                              |
//   out     | out_valid out_ready out_status            | result out
//           | out_start_addr                            |
//
// After acceptance a request of zero size or into a full table goes straight to
// its result, and every other request works through the table: the chunk
// table sits in one RAM, scanned one entry a
// cycle through the shared gap unit up to the chosen slot, then shifted from
// there one entry a cycle through the same read and write ports, so scan and
// shift together cover the table once. in_ready is high only while no request
// is in work, and the result is offered from the cycle in which in_ready rises.
// Reset is synchronous and active low and empties the table at once. A result
// held in the output register does not block the next request; a finished
// request waits for the output register only if the earlier result is still held.
module first_fit_chunk_allocator_top #(
  parameter int unsigned MAX_CHUNKS = ffca_pkg::MAX_CHUNKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [ffca_pkg::LEN_W-1:0]     in_req_size,
  input  logic [ffca_pkg::START_W-1:0]   in_free_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [ffca_pkg::START_W-1:0]   out_start_addr
);
  import ffca_pkg::*;

  localparam int unsigned IDXW = $clog2(MAX_CHUNKS);
  localparam int unsigned CNTW = $clog2(MAX_CHUNKS + 1);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_CHUNKS);
  localparam logic [CNTW-1:0] CNT_ONE = CNTW'(1);

  // Control state.
  ffca_state_t        state_r, state_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers.
  logic [CNTW-1:0]    idx_r, idx_nxt;
  logic [CNTW-1:0]    pos_r, pos_nxt;
  logic [CNTW-1:0]    wr_idx_r, wr_idx_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [END_W-1:0]   prev_end_r, prev_end_nxt;
  logic               kind_r, kind_nxt;
  logic [LEN_W-1:0]   size_r, size_nxt;
  logic [START_W-1:0] faddr_r, faddr_nxt;
  ffca_status_t       res_status_r, res_status_nxt;
  logic [START_W-1:0] res_addr_r, res_addr_nxt;
  ffca_status_t       out_status_r, out_status_nxt;
  logic [START_W-1:0] out_addr_r, out_addr_nxt;

  // Table RAM signals.
  logic               ram_we;
  logic [IDXW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDXW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [START_W-1:0] rd_start;
  logic [LEN_W-1:0]   rd_len;

  // Shared unit signals.
  logic [END_W-1:0]   gu_lhs;
  gap_res_t           gu_res;

  // Table address one below a counter value.
  function automatic logic [IDXW-1:0] idx_nxt_dec(input logic [CNTW-1:0] v);
    logic [CNTW-1:0] t;
    t = v - CNT_ONE;
    return t[IDXW-1:0];
  endfunction

  // Table address one above a counter value.
  function automatic logic [IDXW-1:0] idx_nxt_inc(input logic [CNTW-1:0] v);
    logic [CNTW-1:0] t;
    t = v + CNT_ONE;
    return t[IDXW-1:0];
  endfunction

  // Each entry holds the chunk start above the chunk length.
  ffca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CHUNKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_start = ram_rdata[ENTRY_W-1 -: START_W];
  assign rd_len   = ram_rdata[LEN_W-1:0];

  // The trailing gap is tested as a gap before a chunk that starts at the heap end.
  assign gu_lhs = (state_r == S_TAIL) ? USABLE_END : END_W'(rd_start);

  ffca_gap_unit u_gap (
    .lhs      (gu_lhs),
    .prev_end (prev_end_r),
    .size     (size_r),
    .len      (rd_len),
    .faddr    (faddr_r),
    .res      (gu_res)
  );

  // Sequencer: next state, working registers and table port control.
  always_comb begin
    logic resolved;
    resolved       = 1'b0;
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    wr_idx_nxt     = wr_idx_r;
    chk_v_nxt      = chk_v_r;
    wr_pend_nxt    = wr_pend_r;
    prev_end_nxt   = prev_end_r;
    kind_nxt       = kind_r;
    size_nxt       = size_r;
    faddr_nxt      = faddr_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    ram_we         = 1'b0;
    ram_waddr      = wr_idx_r[IDXW-1:0];
    ram_wdata      = ram_rdata;
    ram_raddr      = idx_r[IDXW-1:0];

    // A held result leaves when the far side takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt     = in_kind;
          size_nxt     = in_req_size;
          faddr_nxt    = in_free_addr;
          prev_end_nxt = '0;
          idx_nxt      = '0;
          chk_v_nxt    = 1'b0;
          wr_pend_nxt  = 1'b0;
          res_addr_nxt = '0;
          if (in_kind == KIND_ALLOC && in_req_size == '0) begin
            res_status_nxt = ST_NOSPACE;
            state_nxt      = S_DONE;
          end else if (in_kind == KIND_ALLOC && cnt_r == CNT_MAX) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // One entry is read per cycle; its data is checked in the next one.
      S_SCAN: begin
        if (chk_v_r) begin
          if (kind_r == KIND_ALLOC) begin
            if (gu_res.fits) begin
              resolved    = 1'b1;
              pos_nxt     = idx_r - CNT_ONE;
              idx_nxt     = cnt_r;
              chk_v_nxt   = 1'b0;
              wr_pend_nxt = 1'b0;
              state_nxt   = S_GROW;
            end else begin
              prev_end_nxt = gu_res.end_val;
            end
          end else if (gu_res.match) begin
            resolved    = 1'b1;
            pos_nxt     = idx_r - CNT_ONE;
            idx_nxt     = idx_r - CNT_ONE;
            chk_v_nxt   = 1'b0;
            wr_pend_nxt = 1'b0;
            state_nxt   = S_SHRINK;
          end
        end
        if (!resolved) begin
          if (idx_r < cnt_r) begin
            ram_raddr = idx_r[IDXW-1:0];
            idx_nxt   = idx_r + CNT_ONE;
            chk_v_nxt = 1'b1;
          end else begin
            chk_v_nxt = 1'b0;
            if (kind_r == KIND_ALLOC) begin
              state_nxt = S_TAIL;
            end else begin
              res_status_nxt = ST_NOTFOUND;
              res_addr_nxt   = '0;
              state_nxt      = S_DONE;
            end
          end
        end
      end

      // Gap between the last chunk and the heap end.
      S_TAIL: begin
        if (gu_res.fits) begin
          pos_nxt     = cnt_r;
          idx_nxt     = cnt_r;
          wr_pend_nxt = 1'b0;
          state_nxt   = S_GROW;
        end else begin
          res_status_nxt = ST_NOSPACE;
          res_addr_nxt   = '0;
          state_nxt      = S_DONE;
        end
      end

      // Move entries from the insert point upwards by one, top entry first.
      S_GROW: begin
        if (wr_pend_r) begin
          ram_we = 1'b1;
        end
        if (idx_r > pos_r) begin
          ram_raddr   = idx_nxt_dec(idx_r);
          wr_idx_nxt  = idx_r;
          wr_pend_nxt = 1'b1;
          idx_nxt     = idx_r - CNT_ONE;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            state_nxt = S_INSERT;
          end
        end
      end

      S_INSERT: begin
        ram_we         = 1'b1;
        ram_waddr      = pos_r[IDXW-1:0];
        ram_wdata      = {prev_end_r[START_W-1:0], size_r};
        cnt_nxt        = cnt_r + CNT_ONE;
        res_status_nxt = ST_OK;
        res_addr_nxt   = prev_end_r[START_W-1:0];
        state_nxt      = S_DONE;
      end

      // Move entries above the freed one down by one, lowest entry first.
      S_SHRINK: begin
        if (wr_pend_r) begin
          ram_we = 1'b1;
        end
        if ((idx_r + CNT_ONE) < cnt_r) begin
          ram_raddr   = idx_nxt_inc(idx_r);
          wr_idx_nxt  = idx_r;
          wr_pend_nxt = 1'b1;
          idx_nxt     = idx_r + CNT_ONE;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            cnt_nxt        = cnt_r - CNT_ONE;
            res_status_nxt = ST_OK;
            res_addr_nxt   = '0;
            state_nxt      = S_DONE;
          end
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
      wr_pend_r   <= wr_pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    wr_idx_r     <= wr_idx_nxt;
    prev_end_r   <= prev_end_nxt;
    kind_r       <= kind_nxt;
    size_r       <= size_nxt;
    faddr_r      <= faddr_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_start_addr = out_addr_r;

endmodule

FILE: sv/ffca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ffca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/ffca_gap_unit.sv
// Shared compare unit: gap fit test, start address match and chunk end sum.
module ffca_gap_unit (
  input  logic [ffca_pkg::END_W-1:0]   lhs,
  input  logic [ffca_pkg::END_W-1:0]   prev_end,
  input  logic [ffca_pkg::LEN_W-1:0]   size,
  input  logic [ffca_pkg::LEN_W-1:0]   len,
  input  logic [ffca_pkg::START_W-1:0] faddr,
  output ffca_pkg::gap_res_t           res
);
  import ffca_pkg::*;

  logic [END_W-1:0] diff;

  // The gap before lhs fits when lhs lies at or above the previous end and the
  // distance covers the requested size. The heap end is fed in as lhs for the
  // trailing gap.
  always_comb begin
    diff        = lhs - prev_end;
    res.fits    = (lhs >= prev_end) && (diff >= END_W'(size));
    res.match   = (lhs == END_W'(faddr));
    res.end_val = lhs + END_W'(len);
  end

endmodule

FILE: sv/ffca_checker.sv
// Port-level checks for the first-fit chunk allocator, bound to the top level.
module ffca_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic [ffca_pkg::START_W-1:0] out_start_addr
);
  import ffca_pkg::*;

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_start_addr))
    else $error("result changed while stalled");

  // Only a granted allocation carries a start address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_start_addr == '0)
    else $error("start address set on a failed request");

  // An accepted request keeps the block busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // Reset leaves no result on offer.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind first_fit_chunk_allocator_top ffca_checker u_ffca_checker (.*);
